// ===== rtl/pva_pkg.sv =====
package pva_pkg;

   localparam int CHANNELS = 8;
   localparam int KEYS     = 64;

   localparam int BITMAP_W   = 64;
   localparam int CHAN_W     = 4;
   localparam int KEYNUM_W   = 7;

   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_CNT_W   = $clog2(CHANNELS + 1);
   localparam int KEY_IDX_W  = $clog2(KEYS);
   localparam int KEY_CNT_W  = $clog2(KEYS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEEP,
      ST_PLACE,
      ST_EMIT
   } pva_state_type;

   typedef struct packed {
      logic load;
      logic keep_step;
      logic place_step;
      logic emit_step;
      logic ptr_clear;
   } pva_cmd_type;

   typedef struct packed {
      logic ch_last;
      logic place_done;
   } pva_status_type;

endpackage

// ===== rtl/pva_ctrl.sv =====
module pva_ctrl
   import pva_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  pva_status_type status,
   output pva_cmd_type    cmd
);

   pva_state_type state_ff;
   pva_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_KEEP;
            end
         end
         ST_KEEP: begin
            cmd.keep_step = 1'b1;
            if (status.ch_last) begin
               cmd.ptr_clear = 1'b1;
               state_in      = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (status.place_done) begin
               cmd.ptr_clear = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.place_step = 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.ch_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pva_datapath.sv =====
module pva_datapath
   import pva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pva_cmd_type         cmd,
   input  logic [BITMAP_W-1:0] key_bitmap,
   output pva_status_type      status,
   output logic [CHAN_W-1:0]   channel,
   output logic [KEYNUM_W-1:0] key_number,
   output logic                started
);

   logic [KEYNUM_W-1:0]  chan_key_ff [CHANNELS];
   logic [CHANNELS-1:0]  fresh_ff;
   logic [KEYS-1:0]      pending_ff;
   logic [KEYS-1:0]      pending_in;
   logic [CH_CNT_W-1:0]  ch_ptr_ff;
   logic [CH_CNT_W-1:0]  ch_ptr_in;
   logic [KEY_CNT_W-1:0] key_ptr_ff;
   logic [KEY_CNT_W-1:0] key_ptr_in;

   logic [CH_IDX_W-1:0]  ch_idx;
   logic [KEY_IDX_W-1:0] key_idx;
   logic [KEYNUM_W-1:0]  cur_key;
   logic [KEYNUM_W-1:0]  cur_key_m1;
   logic [KEY_IDX_W-1:0] held_idx;
   logic                 kept;
   logic                 wr_en;
   logic [KEYNUM_W-1:0]  wr_key;
   logic                 wr_fresh;

   assign ch_idx     = ch_ptr_ff[CH_IDX_W-1:0];
   assign key_idx    = key_ptr_ff[KEY_IDX_W-1:0];
   assign cur_key    = chan_key_ff[ch_idx];
   assign cur_key_m1 = cur_key - KEYNUM_W'(1);
   assign held_idx   = cur_key_m1[KEY_IDX_W-1:0];
   // stored key still held on the keyboard
   assign kept = (cur_key != '0) && (cur_key <= KEYNUM_W'(KEYS)) && pending_ff[held_idx];

   assign status.ch_last    = (ch_ptr_ff == CH_CNT_W'(CHANNELS - 1));
   assign status.place_done = (ch_ptr_ff == CH_CNT_W'(CHANNELS)) ||
                              (key_ptr_ff == KEY_CNT_W'(KEYS));

   assign channel    = CHAN_W'(ch_ptr_ff);
   assign key_number = cur_key;
   assign started    = fresh_ff[ch_idx];

   always_comb begin
      pending_in = pending_ff;
      ch_ptr_in  = ch_ptr_ff;
      key_ptr_in = key_ptr_ff;
      wr_en      = 1'b0;
      wr_key     = '0;
      wr_fresh   = 1'b0;
      if (cmd.load) begin
         pending_in = key_bitmap[KEYS-1:0];
         ch_ptr_in  = '0;
         key_ptr_in = '0;
      end else if (cmd.keep_step) begin
         if (kept) begin
            pending_in[held_idx] = 1'b0;
         end else begin
            wr_en = 1'b1;
         end
         ch_ptr_in = ch_ptr_ff + CH_CNT_W'(1);
      end else if (cmd.place_step) begin
         if (cur_key != '0) begin
            ch_ptr_in = ch_ptr_ff + CH_CNT_W'(1);
         end else if (pending_ff[key_idx]) begin
            wr_en      = 1'b1;
            wr_key     = KEYNUM_W'(key_ptr_ff) + KEYNUM_W'(1);
            wr_fresh   = 1'b1;
            ch_ptr_in  = ch_ptr_ff + CH_CNT_W'(1);
            key_ptr_in = key_ptr_ff + KEY_CNT_W'(1);
         end else begin
            key_ptr_in = key_ptr_ff + KEY_CNT_W'(1);
         end
      end else if (cmd.emit_step) begin
         ch_ptr_in = ch_ptr_ff + CH_CNT_W'(1);
      end
      if (cmd.ptr_clear) begin
         ch_ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
      key_ptr_ff <= key_ptr_in;
      if (reset) begin
         ch_ptr_ff <= '0;
         fresh_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_key_ff[i] <= '0;
         end
      end else begin
         ch_ptr_ff <= ch_ptr_in;
         if (cmd.load) begin
            fresh_ff <= '0;
         end else if (wr_en) begin
            fresh_ff[ch_idx] <= wr_fresh;
         end
         if (wr_en) begin
            chan_key_ff[ch_idx] <= wr_key;
         end
      end
   end

endmodule

// ===== rtl/polyphonic_voice_allocator.sv =====
// channel   ports                                   direction  role
// request   req_valid, req_stall, req_key_bitmap    in         keyboard bitmap, one per scan
// response  rsp_valid, rsp_stall, rsp_channel,      out        one per sound channel, in
//           rsp_key_number, rsp_started, rsp_last              channel order, last flags end
//
// a request is loaded, then handled by a serial walk over channels (hold check), then over
// channels and keys (placement), then by the channel-by-channel response phase
// reset is synchronous and active high; every channel comes out of reset silent
// a stall on the response side holds the current response;
// the request side is stalled from acceptance until the last response is taken
module polyphonic_voice_allocator
   import pva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BITMAP_W-1:0] req_key_bitmap,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CHAN_W-1:0]   rsp_channel,
   output logic [KEYNUM_W-1:0] rsp_key_number,
   output logic                rsp_started,
   output logic                rsp_last
);

   // command and status between sequencer and channel datapath
   pva_cmd_type    cmd;
   pva_status_type status;

   // sequencer: idle, hold check, placement, response phases
   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // channel store, pending key bitmap and the channel and key pointers
   pva_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .key_bitmap (req_key_bitmap),
      .status     (status),
      .channel    (rsp_channel),
      .key_number (rsp_key_number),
      .started    (rsp_started)
   );

   // final channel of the response phase carries the last flag
   assign rsp_last = status.ch_last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
   import pva_pkg::*;
();

   // pacing of both sides and the run as a whole
   localparam int GAP_MAX         = 18;
   localparam int RANDOM_SCANS    = 84;
   localparam int HOLD_OFF_AFTER  = 40;     // requests taken before the long response hold-off
   localparam int HOLD_OFF_CYCLES = 400;    // several scans' worth, so the request side backs up
   localparam int DRAIN_CYCLES    = 150;    // beyond one full scan at the widest
   localparam int CYCLE_LIMIT     = 200000;
   localparam int REPORT_MAX      = 10;

   // one response beat as the block presents it
   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [KEYNUM_W-1:0] key_number;
      logic                started;
      logic                last;
   } voice_type;

   // one keyboard scan; where given is set the channel keys and fresh flags are typed in,
   // otherwise they come from the allocation model below
   typedef struct packed {
      logic [BITMAP_W-1:0]          bitmap;
      logic                         given;
      logic [CHANNELS*KEYNUM_W-1:0] keys;
      logic [CHANNELS-1:0]          fresh;
   } scan_row_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [BITMAP_W-1:0] req_key_bitmap = '0;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CHAN_W-1:0]   rsp_channel;
   logic [KEYNUM_W-1:0] rsp_key_number;
   logic                rsp_started;
   logic                rsp_last;

   // the response stall is the random per-beat back-pressure or the long hold-off
   logic rx_stall   = 1'b0;
   logic hold_stall = 1'b0;
   assign rsp_stall = rx_stall | hold_stall;

   // model copy of the channel store: key number per channel, 0 means silent
   logic [KEYNUM_W-1:0] held_key [CHANNELS];

   voice_type    voices_due [$];
   scan_row_type scan_table [$];

   int   scans_taken = 0;
   int   errors      = 0;
   int   cycles      = 0;
   logic tx_calm     = 1'b0;
   logic rx_calm     = 1'b0;

   polyphonic_voice_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_bitmap (req_key_bitmap),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_channel    (rsp_channel),
      .rsp_key_number (rsp_key_number),
      .rsp_started    (rsp_started),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // allocation model: held keys keep their channel, released channels fall silent,
   // then the remaining held keys go lowest first onto the lowest silent channels
   task automatic allocate_voices(input  logic [BITMAP_W-1:0]          bitmap,
                                  output logic [CHANNELS*KEYNUM_W-1:0] keys,
                                  output logic [CHANNELS-1:0]          fresh);
      logic [BITMAP_W-1:0] pending;
      int                  free_count;
      int                  ch;
      int                  kn;
      int                  k;
      pending = bitmap;
      // bits at and above KEYS play no part
      for (k = 0; k < BITMAP_W; k++) begin
         if (k >= KEYS)
            pending[k] = 1'b0;
      end
      fresh      = '0;
      free_count = 0;
      for (ch = 0; ch < CHANNELS; ch++) begin
         kn = int'(held_key[ch]);
         if (kn == 0) begin
            free_count++;
         end else if (kn <= KEYS && pending[kn-1]) begin
            // still held: the channel keeps it and the key is no longer a candidate
            pending[kn-1] = 1'b0;
         end else begin
            held_key[ch] = '0;
            free_count++;
         end
      end
      // no stealing: once every channel is busy the rest wait for a later scan
      ch = 0;
      for (k = 0; k < KEYS && free_count > 0; k++) begin
         if (pending[k]) begin
            while (ch < CHANNELS && held_key[ch] != '0)
               ch++;
            if (ch >= CHANNELS)
               break;
            held_key[ch] = KEYNUM_W'(k + 1);
            fresh[ch]    = 1'b1;
            free_count--;
         end
      end
      for (ch = 0; ch < CHANNELS; ch++)
         keys[ch*KEYNUM_W +: KEYNUM_W] = held_key[ch];
   endtask

   function automatic scan_row_type make_row(input logic [BITMAP_W-1:0]          bitmap,
                                             input logic                         given,
                                             input logic [CHANNELS*KEYNUM_W-1:0] keys,
                                             input logic [CHANNELS-1:0]          fresh);
      scan_row_type r;
      r.bitmap = bitmap;
      r.given  = given;
      r.keys   = keys;
      r.fresh  = fresh;
      return r;
   endfunction

   // offer one scan after a random gap, wait for the block to take it, then queue the
   // responses it owes; entered and left at a falling edge
   task automatic send_scan(input scan_row_type row);
      int                           gap;
      int                           c;
      logic [CHANNELS*KEYNUM_W-1:0] keys;
      logic [CHANNELS-1:0]          fresh;
      voice_type                    v;
      // now and then switch between gappy and back-to-back offering
      if ($urandom_range(0, 15) == 0)
         tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_key_bitmap <= row.bitmap;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      // the model always runs so its channel store tracks the block
      allocate_voices(row.bitmap, keys, fresh);
      if (row.given) begin
         keys  = row.keys;
         fresh = row.fresh;
      end
      for (c = 0; c < CHANNELS; c++) begin
         v.channel    = CHAN_W'(c);
         v.key_number = keys[c*KEYNUM_W +: KEYNUM_W];
         v.started    = fresh[c];
         v.last       = (c == CHANNELS - 1);
         voices_due.push_back(v);
      end
      scans_taken++;
      @(negedge clock);
   endtask

   // stimulus: reset, directed scans, then random keyboard activity, then drain
   initial begin
      logic [BITMAP_W-1:0] keyboard;
      int                  pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (held_key[c])
         held_key[c] = '0;

      // typed rows assume eight channels, keys listed from channel 7 down to channel 0
      // nothing held straight after reset: every channel silent
      scan_table.push_back(make_row(64'h0, 1'b1, '0, '0));
      // every key held: lowest eight keys land on channels 0 to 7, all newly started
      scan_table.push_back(make_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
         {7'd8, 7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}, 8'hFF));
      // same again: all keep their keys, nothing restarts
      scan_table.push_back(make_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
         {7'd8, 7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}, 8'h00));
      // full release
      scan_table.push_back(make_row(64'h0, 1'b1, '0, '0));
      // top key alone
      scan_table.push_back(make_row(64'h8000_0000_0000_0000, 1'b1,
         {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd64}, 8'h01));
      // top key kept, bottom key joins on the next channel
      scan_table.push_back(make_row(64'h8000_0000_0000_0001, 1'b1,
         {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd64}, 8'h02));
      // both released while key 2 is pressed: channel 0 is freed and retaken at once
      scan_table.push_back(make_row(64'h0000_0000_0000_0002, 1'b1,
         {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd2}, 8'h01));
      // one key kept among a new chord wider than the free channels
      scan_table.push_back(make_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, '0));
      // all channels busy and held: the extra keys are dropped, nobody is stolen from
      scan_table.push_back(make_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, '0));
      // everything released and a disjoint chord pressed in the same scan
      scan_table.push_back(make_row(64'h5555_5555_5555_5555, 1'b0, '0, '0));
      // dropped keys still held are looked at again once a channel frees up
      scan_table.push_back(make_row(64'h0000_0000_0000_FFFF, 1'b0, '0, '0));
      scan_table.push_back(make_row(64'h0000_0000_0000_FFFE, 1'b0, '0, '0));
      // upper half of the keyboard only
      scan_table.push_back(make_row(64'hFFFF_FFFF_0000_0000, 1'b0, '0, '0));
      scan_table.push_back(make_row(64'h8000_0001_0000_0000, 1'b0, '0, '0));
      // scattered keys with gaps between channels
      scan_table.push_back(make_row(64'h0100_0010_0200_4008, 1'b0, '0, '0));
      // final release, every channel silent again
      scan_table.push_back(make_row(64'h0, 1'b1, '0, '0));

      foreach (scan_table[i])
         send_scan(scan_table[i]);

      // random part: mostly a keyboard that changes a few keys at a time, the rest noise
      keyboard = '0;
      repeat (RANDOM_SCANS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            // press or release one to three keys
            repeat ($urandom_range(1, 3))
               keyboard[$urandom_range(0, BITMAP_W - 1)] ^= 1'b1;
         end else if (pick == 6) begin
            keyboard = {$urandom, $urandom};
         end else if (pick == 7) begin
            keyboard = '0;
            repeat ($urandom_range(1, 10))
               keyboard[$urandom_range(0, BITMAP_W - 1)] = 1'b1;
         end else if (pick == 8) begin
            keyboard = $urandom_range(0, 1) ? '0 : '1;
         end else begin
            keyboard = {$urandom, $urandom} & {$urandom, $urandom};
         end
         send_scan(make_row(keyboard, 1'b0, '0, '0));
      end
      req_valid <= 1'b0;

      // wait for every owed response, then give any stray beat time to show up
      while (voices_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stall before each beat, then compare with the oldest owed beat
   initial begin
      int        n;
      voice_type got;
      voice_type want;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rx_calm = !rx_calm;
         n = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
         if (n > 0) begin
            rx_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rx_stall <= 1'b0;
         do
            @(posedge clock);
         while (!(rsp_valid && !rsp_stall));
         got.channel    = rsp_channel;
         got.key_number = rsp_key_number;
         got.started    = rsp_started;
         got.last       = rsp_last;
         if (voices_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected response: channel %0d key %0d started %0b last %0b",
                        got.channel, got.key_number, got.started, got.last);
         end else begin
            want = voices_due.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display({"response mismatch: expected ch %0d key %0d started %0b last %0b,",
                            " got ch %0d key %0d started %0b last %0b"},
                           want.channel, want.key_number, want.started, want.last,
                           got.channel, got.key_number, got.started, got.last);
            end
         end
         @(negedge clock);
      end
   end

   // long hold-off on the response side while requests keep being offered,
   // so the block stays full and holds its request stall
   initial begin
      wait (scans_taken >= HOLD_OFF_AFTER);
      @(negedge clock);
      hold_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      hold_stall <= 1'b0;
   end

   // run limit, well above the slowest legal run
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
